[hw/rtl/rbes_pkg.sv]
package rbes_pkg;

	localparam int QW = 32;

	typedef enum logic [2:0] {
		REG_INV_MASS = 3'd0,
		REG_TIME_STEP = 3'd1,
		REG_INERTIA0 = 3'd2,
		REG_INERTIA1 = 3'd3,
		REG_INERTIA2 = 3'd4
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LIN,
		ST_ANG,
		ST_POS,
		ST_HALF,
		ST_QUAT,
		ST_NORM,
		ST_SQRT,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic start_lin;
		logic start_ang;
		logic start_pos;
		logic start_half;
		logic start_quat;
		logic start_norm;
		logic start_sqrt;
		logic start_div;
		logic load_in;
	} cmd_t;

	typedef struct packed {
		logic done;
	} sts_t;

	typedef struct packed {
		logic signed [31:0] force_x;
		logic signed [31:0] force_y;
		logic signed [31:0] force_z;
		logic signed [31:0] torque_x;
		logic signed [31:0] torque_y;
		logic signed [31:0] torque_z;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] rot_w;
		logic signed [31:0] rot_x;
		logic signed [31:0] rot_y;
		logic signed [31:0] rot_z;
	} out_item_t;

	function automatic logic signed [31:0] sat32(input logic signed [79:0] x);
		if (x > 80'sd2147483647) return 32'sh7fffffff;
		if (x < -80'sd2147483648) return 32'sh80000000;
		return x[31:0];
	endfunction

endpackage

[hw/rtl/rbes_if.sv]
interface rbes_in_if import rbes_pkg::*; ();
	logic valid;
	logic ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rbes_out_if import rbes_pkg::*; ();
	logic valid;
	logic ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/rbes_ctrl.sv]
module rbes_ctrl import rbes_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_fire,
	input logic out_busy,
	input sts_t sts,
	output cmd_t cmd,
	output logic idle,
	output logic out_load
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_fire) state_d = ST_LIN;
			ST_LIN: if (sts.done) state_d = ST_ANG;
			ST_ANG: if (sts.done) state_d = ST_POS;
			ST_POS: if (sts.done) state_d = ST_HALF;
			ST_HALF: if (sts.done) state_d = ST_QUAT;
			ST_QUAT: if (sts.done) state_d = ST_NORM;
			ST_NORM: if (sts.done) state_d = ST_SQRT;
			ST_SQRT: if (sts.done) state_d = ST_DIV;
			ST_DIV: if (sts.done) state_d = ST_OUT;
			ST_OUT: if (!out_busy) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		idle = (state_q == ST_IDLE);
		out_load = (state_q == ST_OUT) && !out_busy;
		cmd.load_in = (state_q == ST_IDLE) && in_fire;
		case (state_q)
			ST_LIN: cmd.start_lin = 1'b1;
			ST_ANG: cmd.start_ang = 1'b1;
			ST_POS: cmd.start_pos = 1'b1;
			ST_HALF: cmd.start_half = 1'b1;
			ST_QUAT: cmd.start_quat = 1'b1;
			ST_NORM: cmd.start_norm = 1'b1;
			ST_SQRT: cmd.start_sqrt = 1'b1;
			ST_DIV: cmd.start_div = 1'b1;
			default: ;
		endcase
	end
endmodule

[hw/rtl/rbes_dp.sv]
module rbes_dp import rbes_pkg::*; #(
	parameter int WORD_WIDTH = 32
) (
	input logic clk,
	input logic arst_n,
	input cmd_t cmd,
	output sts_t sts,
	input in_item_t in_data,
	input logic [31:0] inv_mass,
	input logic [31:0] time_step,
	input logic [47:0] rows [3],
	output out_item_t res
);
	localparam int EW = (WORD_WIDTH > 32) ? 32 : ((WORD_WIDTH < 16) ? 16 : WORD_WIDTH);
	localparam logic signed [79:0] WHI = (80'sd1 <<< (EW - 1)) - 80'sd1;
	localparam logic signed [79:0] WLO = -WHI - 80'sd1;

	function automatic logic signed [31:0] satw(input logic signed [79:0] x);
		if (x > WHI) return WHI[31:0];
		if (x < WLO) return WLO[31:0];
		return x[31:0];
	endfunction

	in_item_t in_q;
	logic signed [31:0] pos_q [3];
	logic signed [31:0] lv_q [3];
	logic signed [31:0] av_q [3];
	logic signed [31:0] q_q [4];
	logic signed [31:0] a_q [3];
	logic signed [31:0] nq_q [4];
	logic signed [31:0] t_q;
	logic signed [79:0] acc_q;
	logic [63:0] n_q, rem_q, root_q, bit_q;
	logic [63:0] num_q, quo_q, drem_q;
	logic [2:0] i_q;
	logic [2:0] ph_q;
	logic [6:0] k_q;

	// one shared multiplier, operands chosen by step
	logic signed [32:0] ma, mb;
	logic signed [65:0] prod;
	logic signed [31:0] fsel [3];
	logic signed [31:0] tsel [3];
	logic signed [15:0] ient;
	logic [1:0] ii;
	logic [1:0] jj;

	assign fsel[0] = in_q.force_x;
	assign fsel[1] = in_q.force_y;
	assign fsel[2] = in_q.force_z;
	assign tsel[0] = in_q.torque_x;
	assign tsel[1] = in_q.torque_y;
	assign tsel[2] = in_q.torque_z;
	assign ii = i_q[1:0];
	assign jj = ph_q[1:0];
	assign ient = rows[ii][16*jj +: 16];

	// quaternion product term table: coefficient a index, q index, sign
	logic [1:0] qa_i, qq_i;
	logic qneg, qa_one;
	always_comb begin
		qa_i = 2'd0; qq_i = 2'd0; qneg = 1'b0; qa_one = 1'b0;
		case ({ii, jj})
			4'h0: begin qa_i = 2'd0; qq_i = 2'd1; qneg = 1'b1; end
			4'h1: begin qa_i = 2'd1; qq_i = 2'd2; qneg = 1'b1; end
			4'h2: begin qa_i = 2'd2; qq_i = 2'd3; qneg = 1'b1; end
			4'h4: begin qa_i = 2'd0; qq_i = 2'd0; end
			4'h5: begin qa_i = 2'd1; qq_i = 2'd3; end
			4'h6: begin qa_i = 2'd2; qq_i = 2'd2; qneg = 1'b1; end
			4'h8: begin qa_i = 2'd1; qq_i = 2'd0; end
			4'h9: begin qa_i = 2'd2; qq_i = 2'd1; end
			4'hA: begin qa_i = 2'd0; qq_i = 2'd3; qneg = 1'b1; end
			4'hC: begin qa_i = 2'd2; qq_i = 2'd0; end
			4'hD: begin qa_i = 2'd0; qq_i = 2'd2; end
			4'hE: begin qa_i = 2'd1; qq_i = 2'd1; qneg = 1'b1; end
			default: qa_one = 1'b1;
		endcase
	end

	always_comb begin
		ma = '0; mb = '0;
		if (cmd.start_lin) begin
			ma = (ph_q == 3'd0) ? 33'(fsel[ii]) : 33'(t_q);
			mb = (ph_q == 3'd0) ? {1'b0, inv_mass} : {1'b0, time_step};
		end else if (cmd.start_ang) begin
			ma = (ph_q == 3'd3) ? 33'(t_q) : 33'(tsel[jj]);
			mb = (ph_q == 3'd3) ? {1'b0, time_step} : 33'(ient);
		end else if (cmd.start_pos) begin
			ma = 33'(lv_q[ii]); mb = {1'b0, time_step};
		end else if (cmd.start_half) begin
			ma = 33'(av_q[ii]); mb = {1'b0, time_step};
		end else if (cmd.start_quat) begin
			ma = 33'(a_q[qa_i]); mb = 33'(q_q[qq_i]);
		end else if (cmd.start_norm) begin
			ma = 33'(nq_q[ii]); mb = 33'(nq_q[ii]);
		end
		prod = ma * mb;
	end

	logic [63:0] dtrial;
	logic [63:0] dnext_rem;
	logic signed [79:0] rq;
	assign dnext_rem = {drem_q[62:0], num_q[63]};
	assign dtrial = dnext_rem - root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0; lv_q[i] <= '0; av_q[i] <= '0; a_q[i] <= '0;
			end
			for (int i = 0; i < 4; i++) nq_q[i] <= '0;
			q_q[0] <= 32'sh40000000; q_q[1] <= '0; q_q[2] <= '0; q_q[3] <= '0;
			in_q <= '0; t_q <= '0; acc_q <= '0;
			n_q <= '0; rem_q <= '0; root_q <= '0; bit_q <= '0;
			num_q <= '0; quo_q <= '0; drem_q <= '0;
			i_q <= '0; ph_q <= '0; k_q <= '0;
			sts.done <= 1'b0;
		end else begin
			sts.done <= 1'b0;
			if (cmd.load_in) begin
				in_q <= in_data; i_q <= '0; ph_q <= '0; k_q <= '0; acc_q <= '0;
			end
			if (cmd.start_lin && !sts.done) begin
				if (ph_q == 3'd0) begin
					t_q <= satw(80'(prod >>> 16)); ph_q <= 3'd1;
				end else begin
					lv_q[ii] <= satw(80'(lv_q[ii]) + 80'(satw(80'(prod >>> 16))));
					ph_q <= '0;
					if (i_q == 3'd2) begin i_q <= '0; sts.done <= 1'b1; end
					else i_q <= i_q + 3'd1;
				end
			end
			if (cmd.start_ang && !sts.done) begin
				if (ph_q < 3'd3) begin
					if (ph_q == 3'd2) t_q <= satw((acc_q + 80'(prod)) >>> 8);
					else acc_q <= acc_q + 80'(prod);
					ph_q <= ph_q + 3'd1;
				end else begin
					av_q[ii] <= satw(80'(av_q[ii]) + 80'(satw(80'(prod >>> 16))));
					ph_q <= '0; acc_q <= '0;
					if (i_q == 3'd2) begin i_q <= '0; sts.done <= 1'b1; end
					else i_q <= i_q + 3'd1;
				end
			end
			if (cmd.start_pos && !sts.done) begin
				pos_q[ii] <= satw(80'(pos_q[ii]) + 80'(satw(80'(prod >>> 16))));
				if (i_q == 3'd2) begin i_q <= '0; sts.done <= 1'b1; end
				else i_q <= i_q + 3'd1;
			end
			if (cmd.start_half && !sts.done) begin
				a_q[ii] <= sat32(80'(prod >>> 3));
				if (i_q == 3'd2) begin i_q <= '0; sts.done <= 1'b1; end
				else i_q <= i_q + 3'd1;
			end
			if (cmd.start_quat && !sts.done) begin
				if (ph_q < 3'd3) begin
					acc_q <= qneg ? acc_q - 80'(prod >>> 30) : acc_q + 80'(prod >>> 30);
					ph_q <= ph_q + 3'd1;
				end else begin
					nq_q[ii] <= sat32(80'(q_q[ii]) + acc_q);
					acc_q <= '0; ph_q <= '0;
					if (i_q == 3'd3) begin i_q <= '0; sts.done <= 1'b1; n_q <= '0; end
					else i_q <= i_q + 3'd1;
				end
			end
			if (cmd.start_norm && !sts.done) begin
				if (i_q == 3'd3) begin
					rem_q <= n_q + (prod[63:0] >> 2);
					root_q <= '0; bit_q <= 64'd1 << 62;
					i_q <= '0; sts.done <= 1'b1;
				end else begin
					n_q <= n_q + (prod[63:0] >> 2);
					i_q <= i_q + 3'd1;
				end
			end
			if (cmd.start_sqrt && !sts.done) begin
				// one result bit per cycle, 32 steps
				if (rem_q >= root_q + bit_q) begin
					rem_q <= rem_q - (root_q + bit_q);
					root_q <= (root_q >> 1) + bit_q;
				end else root_q <= root_q >> 1;
				bit_q <= bit_q >> 2;
				if (bit_q[0]) begin sts.done <= 1'b1; k_q <= '0; i_q <= '0; end
			end
			if (cmd.start_div && !sts.done) begin
				if (root_q == 64'd0) begin
					q_q[0] <= 32'sh40000000; q_q[1] <= '0; q_q[2] <= '0; q_q[3] <= '0;
					sts.done <= 1'b1;
				end else if (k_q == 7'd0) begin
					num_q <= {3'd0, (nq_q[ii] < 0) ? 32'(-33'(nq_q[ii])) : nq_q[ii], 29'd0};
					drem_q <= '0; quo_q <= '0; k_q <= 7'd1;
				end else if (k_q <= 7'd64) begin
					if (dnext_rem >= root_q) begin
						drem_q <= dtrial; quo_q <= {quo_q[62:0], 1'b1};
					end else begin
						drem_q <= dnext_rem; quo_q <= {quo_q[62:0], 1'b0};
					end
					num_q <= num_q << 1;
					k_q <= k_q + 7'd1;
				end else begin
					q_q[ii] <= sat32(rq);
					k_q <= '0;
					if (i_q == 3'd3) begin i_q <= '0; sts.done <= 1'b1; end
					else i_q <= i_q + 3'd1;
				end
			end
		end
	end

	assign rq = nq_q[ii][31] ? -80'(quo_q) : 80'(quo_q);

	assign res.pos_x = pos_q[0];
	assign res.pos_y = pos_q[1];
	assign res.pos_z = pos_q[2];
	assign res.rot_w = q_q[0];
	assign res.rot_x = q_q[1];
	assign res.rot_y = q_q[2];
	assign res.rot_z = q_q[3];

	logic unused;
	assign unused = qa_one;
endmodule

[hw/rtl/rigid_body_euler_step.sv]
// One symplectic Euler tick of a rigid body per request: velocities, then
// position, then quaternion update and renormalization. Work is sequential
// over one shared 33x33 multiplier, a bit-serial square root and a
// restoring divider that works one quaternion component at a time. One
// request is worked at a time and the pose waits in an output register while
// the next request is taken.
module rigid_body_euler_step import rbes_pkg::*; #(
	parameter int WORD_WIDTH = 32
) (
	input logic clk,
	input logic arst_n,
	rbes_in_if.sink in_ch,
	rbes_out_if.source out_ch,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [47:0] cfg_data
);
	// configuration registers
	logic [31:0] inv_mass_q, time_step_q;
	logic [47:0] rows_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_mass_q <= 32'd65536;
			time_step_q <= 32'd1092;
			rows_q[0] <= 48'd256;
			rows_q[1] <= 48'd16777216;
			rows_q[2] <= 48'd1099511627776;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_INV_MASS: inv_mass_q <= cfg_data[31:0];
				REG_TIME_STEP: time_step_q <= cfg_data[31:0];
				REG_INERTIA0: rows_q[0] <= cfg_data;
				REG_INERTIA1: rows_q[1] <= cfg_data;
				REG_INERTIA2: rows_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	cmd_t cmd;
	sts_t sts;
	logic idle, out_load, out_valid_q;
	out_item_t res, out_q;
	logic in_fire;

	// new request allowed while the previous pose still waits
	assign in_ch.ready = idle;
	assign in_fire = in_ch.valid && idle;

	rbes_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire),
		.out_busy(out_valid_q && !out_ch.ready),
		.sts(sts), .cmd(cmd), .idle(idle), .out_load(out_load)
	);

	rbes_dp #(.WORD_WIDTH(WORD_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_data(in_ch.data), .inv_mass(inv_mass_q), .time_step(time_step_q),
		.rows(rows_q), .res(res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (out_load) out_valid_q <= 1'b1;
		else if (out_ch.ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) out_q <= res;
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data = out_q;

`ifndef SYNTHESIS
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || out_ch.ready)) else $error("pose overwritten");
	a_busy_noaccept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ch.ready) else $error("second request during work");
`endif
endmodule

[sim/rbes_scoreboard.sv]
`timescale 1ns / 1ps

module rbes_scoreboard import rbes_pkg::*; #(
	parameter int WORD_WIDTH = 32
) (
	input logic clk,
	input logic arst_n,
	rbes_in_if in_ch,
	rbes_out_if out_ch,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [47:0] cfg_data,
	output int errors,
	output int pending
);

	localparam int EW = WORD_WIDTH > 32 ? 32 : (WORD_WIDTH < 16 ? 16 : WORD_WIDTH);
	localparam longint Q30_ONE = 64'sd1 <<< 30;

	logic [31:0] inv_mass_r, dt_r;
	logic [47:0] inertia_r [3];
	longint pos_s [3];
	longint vel_s [3];
	longint omega_s [3];
	longint quat_s [4];
	out_item_t pose_q [$];

	function automatic longint clamp(longint x, int w);
		longint hi, lo;
		hi = (64'sd1 <<< (w - 1)) - 1;
		lo = -hi - 1;
		return x > hi ? hi : (x < lo ? lo : x);
	endfunction

	function automatic longint unsigned root64(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// one tick of the body; updates the mirrored state and returns the pose
	function automatic out_item_t integrate_tick(in_item_t it);
		longint f [3], tq [3], a [3], q [4], nq [4];
		longint dt, im, acc, dv, sum, aacc, dw, dp, r;
		longint unsigned n, s, mag;
		out_item_t p;
		dt = longint'(dt_r);
		im = longint'(inv_mass_r);
		f[0] = it.force_x; f[1] = it.force_y; f[2] = it.force_z;
		tq[0] = it.torque_x; tq[1] = it.torque_y; tq[2] = it.torque_z;
		for (int i = 0; i < 3; i++) begin
			acc = clamp((f[i] * im) >>> 16, EW);
			dv = clamp((acc * dt) >>> 16, EW);
			vel_s[i] = clamp(vel_s[i] + dv, EW);
			sum = 0;
			for (int j = 0; j < 3; j++)
				sum += longint'($signed(inertia_r[i][16*j +: 16])) * tq[j];
			aacc = clamp(sum >>> 8, EW);
			dw = clamp((aacc * dt) >>> 16, EW);
			omega_s[i] = clamp(omega_s[i] + dw, EW);
		end
		for (int i = 0; i < 3; i++) begin
			dp = clamp((vel_s[i] * dt) >>> 16, EW);
			pos_s[i] = clamp(pos_s[i] + dp, EW);
		end
		for (int i = 0; i < 3; i++)
			a[i] = clamp((omega_s[i] * dt) >>> 3, 32);
		q = quat_s;
		nq[0] = q[0] - (((a[0] * q[1]) >>> 30) + ((a[1] * q[2]) >>> 30)
			+ ((a[2] * q[3]) >>> 30));
		nq[1] = q[1] + ((q[0] * a[0]) >>> 30) + ((a[1] * q[3]) >>> 30)
			- ((a[2] * q[2]) >>> 30);
		nq[2] = q[2] + ((q[0] * a[1]) >>> 30) + ((a[2] * q[1]) >>> 30)
			- ((a[0] * q[3]) >>> 30);
		nq[3] = q[3] + ((q[0] * a[2]) >>> 30) + ((a[0] * q[2]) >>> 30)
			- ((a[1] * q[1]) >>> 30);
		n = 0;
		for (int i = 0; i < 4; i++) begin
			nq[i] = clamp(nq[i], 32);
			n += longint'(nq[i] * nq[i]) >> 2;
		end
		s = root64(n);
		if (s == 0) begin
			quat_s[0] = Q30_ONE;
			quat_s[1] = 0; quat_s[2] = 0; quat_s[3] = 0;
		end else begin
			for (int i = 0; i < 4; i++) begin
				mag = nq[i] < 0 ? -nq[i] : nq[i];
				r = longint'((mag << 29) / s);
				quat_s[i] = clamp(nq[i] < 0 ? -r : r, 32);
			end
		end
		p.pos_x = pos_s[0][31:0]; p.pos_y = pos_s[1][31:0]; p.pos_z = pos_s[2][31:0];
		p.rot_w = quat_s[0][31:0]; p.rot_x = quat_s[1][31:0];
		p.rot_y = quat_s[2][31:0]; p.rot_z = quat_s[3][31:0];
		return p;
	endfunction

	function automatic int field_bad(string name, logic [31:0] e, logic [31:0] got);
		if (e === got)
			return 0;
		$error("%s: expected %0d, got %0d", name, $signed(e), $signed(got));
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t e, got;
		int bad;
		if (!arst_n) begin
			inv_mass_r <= 32'd65536;
			dt_r <= 32'd1092;
			inertia_r[0] <= 48'd256;
			inertia_r[1] <= 48'd256 << 16;
			inertia_r[2] <= 48'd256 << 32;
			for (int i = 0; i < 3; i++) begin
				pos_s[i] = 0; vel_s[i] = 0; omega_s[i] = 0;
			end
			quat_s[0] = Q30_ONE;
			quat_s[1] = 0; quat_s[2] = 0; quat_s[3] = 0;
			pose_q.delete();
			errors <= 0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_INV_MASS: inv_mass_r <= cfg_data[31:0];
					REG_TIME_STEP: dt_r <= cfg_data[31:0];
					REG_INERTIA0: inertia_r[0] <= cfg_data;
					REG_INERTIA1: inertia_r[1] <= cfg_data;
					REG_INERTIA2: inertia_r[2] <= cfg_data;
					default: ;
				endcase
			end
			if (in_ch.valid && in_ch.ready)
				pose_q.push_back(integrate_tick(in_ch.data));
			if (out_ch.valid && out_ch.ready) begin
				got = out_ch.data;
				if (pose_q.size() == 0) begin
					$error("pose out with no request pending");
					errors <= errors + 1;
				end else begin
					e = pose_q.pop_front();
					bad = field_bad("pos_x", e.pos_x, got.pos_x)
						+ field_bad("pos_y", e.pos_y, got.pos_y)
						+ field_bad("pos_z", e.pos_z, got.pos_z)
						+ field_bad("rot_w", e.rot_w, got.rot_w)
						+ field_bad("rot_x", e.rot_x, got.rot_x)
						+ field_bad("rot_y", e.rot_y, got.rot_y)
						+ field_bad("rot_z", e.rot_z, got.rot_z);
					if (bad != 0)
						errors <= errors + 1;
				end
			end
		end
	end

	assign pending = pose_q.size();

endmodule

[sim/tb_rigid_body_euler_step.sv]
`timescale 1ns / 1ps

module tb_rigid_body_euler_step;
	import rbes_pkg::*;

	// an index outside the register map, written to check it is ignored
	localparam logic [2:0] IDX_UNUSED = 3'd6;
	// room for the block to settle after the last pose is back
	localparam int DRAIN_CYCLES = 600;
	localparam int IDLE_LIMIT = 20000;
	localparam int RANDOM_PER_PHASE = 262;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [47:0] cfg_data = '0;
	int errors, pending;
	int idle_cycles = 0;
	bit no_gaps = 1'b0;
	int stall_left = 0;

	rbes_in_if in_ch ();
	rbes_out_if out_ch ();

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	rigid_body_euler_step dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	rbes_scoreboard chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.errors(errors),
		.pending(pending)
	);

	// pose receiver: mostly ready, short stalls, now and then a long one
	always @(posedge clk) begin
		int r;
		r = $urandom_range(0, 99);
		if (stall_left > 0) begin
			out_ch.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (no_gaps || r < 65) begin
			out_ch.ready <= 1'b1;
		end else if (r < 97) begin
			out_ch.ready <= 1'b0;
			stall_left <= $urandom_range(0, 4);
		end else begin
			out_ch.ready <= 1'b0;
			stall_left <= $urandom_range(30, 200);
		end
	end

	// watchdog: too long with no handshake on either side means a hang
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// all five registers plus one unmapped index, back to back
	task automatic load_settings(logic [31:0] im, logic [31:0] dt,
		logic [47:0] r0, logic [47:0] r1, logic [47:0] r2);
		logic [47:0] vals [6];
		logic [2:0] idx [6];
		vals = '{48'(im), 48'(dt), r0, r1, r2, 48'({$urandom, $urandom})};
		idx = '{REG_INV_MASS, REG_TIME_STEP, REG_INERTIA0, REG_INERTIA1,
			REG_INERTIA2, IDX_UNUSED};
		for (int k = 0; k < 6; k++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[k];
			cfg_data <= vals[k];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// sender side holds off until every pose has come back, then lets the
	// block settle before anything else happens
	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// one request; returns at the edge where it was taken
	task automatic send_request(in_item_t it);
		int r, gap;
		bit took;
		r = $urandom_range(0, 99);
		gap = (no_gaps || r < 60) ? 0 :
			(r < 90 ? $urandom_range(1, 3) :
			(r < 98 ? $urandom_range(4, 20) : $urandom_range(50, 200)));
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= it;
		do begin
			@(negedge clk);
			took = in_ch.ready;
			@(posedge clk);
		end while (!took);
	endtask

	function automatic logic [31:0] pick_value(int kind);
		case (kind)
			0: return 32'($signed($urandom_range(0, 131072)) - 65536);
			1: return 32'($signed($urandom_range(0, 33554432)) - 16777216);
			2: return $urandom;
			default: begin
				case ($urandom_range(0, 3))
					0: return 32'h7fffffff;
					1: return 32'h80000000;
					2: return 32'h0;
					default: return 32'hffffffff;
				endcase
			end
		endcase
	endfunction

	// mostly small forces so the body wanders instead of pinning at the rails
	function automatic in_item_t random_request();
		in_item_t it;
		int r, kind;
		r = $urandom_range(0, 99);
		kind = r < 55 ? 0 : (r < 80 ? 1 : (r < 95 ? 2 : 3));
		it.force_x = pick_value(kind);
		it.force_y = pick_value(kind);
		it.force_z = pick_value(kind);
		it.torque_x = pick_value(kind);
		it.torque_y = pick_value(kind);
		it.torque_z = pick_value(kind);
		return it;
	endfunction

	function automatic in_item_t uniform_request(logic [31:0] v);
		in_item_t it;
		it = '{v, v, v, v, v, v};
		return it;
	endfunction

	function automatic logic [47:0] random_row();
		logic [47:0] row;
		row = 48'({$urandom, $urandom});
		// keep about half of the rows near unity so orientation keeps moving
		if ($urandom_range(0, 1))
			for (int j = 0; j < 3; j++)
				row[16*j +: 16] = 16'($signed($urandom_range(0, 1024)) - 512);
		return row;
	endfunction

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes under the reset settings
		send_request(uniform_request(32'h0));
		send_request(uniform_request(32'h7fffffff));
		send_request(uniform_request(32'h80000000));
		send_request(uniform_request(32'hffffffff));
		send_request(uniform_request(32'h00010000));
		send_request(in_item_t'{32'h7fffffff, 32'h80000000, 32'h0,
			32'h80000000, 32'h7fffffff, 32'h0});
		send_request(in_item_t'{32'h0, 32'h0, 32'h0, 32'h7fffffff, 32'h0, 32'h0});
		send_request(in_item_t'{32'h0, 32'h0, 32'h0, 32'h0, 32'h80000000, 32'h0});
		send_request(in_item_t'{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h7fffffff});
		send_request(uniform_request(32'haaaaaaaa));
		send_request(uniform_request(32'h55555555));
		drain();

		// zero inverse mass and identity inertia
		load_settings(32'h0, 32'd1092, 48'd256, 48'd256 << 16, 48'd256 << 32);
		send_request(uniform_request(32'h7fffffff));
		send_request(uniform_request(32'h80000000));
		drain();
		// largest dt with extreme inertia entries drives the quaternion to its
		// rails, where the sum can collapse to zero and reset to identity
		load_settings(32'hffffffff, 32'hffffffff, 48'h7fff7fff7fff,
			48'h800080008000, 48'hffffffffffff);
		send_request(uniform_request(32'h7fffffff));
		send_request(uniform_request(32'h80000000));
		send_request(uniform_request(32'h12345678));
		drain();
		load_settings(32'hffffffff, 32'h0, 48'h0, 48'h0, 48'h0);
		send_request(uniform_request(32'h7fffffff));
		send_request(uniform_request(32'h80000000));
		drain();

		// random phases, each under its own settings
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: load_settings(32'd65536, 32'd1092, 48'd256, 48'd256 << 16,
					48'd256 << 32);
				1: load_settings(32'h0, 32'd655, random_row(), random_row(),
					random_row());
				2: load_settings($urandom, $urandom, random_row(), random_row(),
					random_row());
				3: load_settings(32'($urandom_range(0, 262144)),
					32'($urandom_range(0, 65536)), random_row(), random_row(),
					random_row());
				4: load_settings(32'hffffffff, 32'hffffffff, random_row(),
					random_row(), random_row());
				5: load_settings(32'd65536, 32'h0, random_row(), random_row(),
					random_row());
				default: load_settings(32'd65536, 32'd1092, 48'd256, 48'd256 << 16,
					48'd256 << 32);
			endcase
			no_gaps = (ph == 3);
			for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
				send_request(random_request());
				// now and then hold off until everything is back
				if ($urandom_range(0, 99) == 0) begin
					in_ch.valid <= 1'b0;
					@(posedge clk);
					while (pending != 0)
						@(posedge clk);
				end
			end
			no_gaps = 1'b0;
			drain();
		end

		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
